>>> hdl/alm_pkg.sv
// Shared types and codes for the array list with middle insert.
// Used by alm_engine and array_list_middle_insert; no dependencies.
`default_nettype none

package alm_pkg;

	localparam int CAPACITY_DEF = 64;

	localparam logic [2:0] CMD_APPEND     = 3'd0;
	localparam logic [2:0] CMD_DROP_LAST  = 3'd1;
	localparam logic [2:0] CMD_INSERT_MID = 3'd2;
	localparam logic [2:0] CMD_REMOVE_MID = 3'd3;
	localparam logic [2:0] CMD_SEARCH     = 3'd4;
	localparam logic [2:0] CMD_CLEAR      = 3'd5;

	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic [2:0]         command;
		logic signed [31:0] value;
	} in_t;

	typedef struct packed {
		logic [1:0] status;
		logic       found;
		logic [6:0] count;
		logic       is_full;
		logic       is_empty;
	} out_t;

	// top -> engine
	typedef struct packed {
		logic start;
		logic take;
	} eng_ctl_t;

	// engine -> top
	typedef struct packed {
		logic idle;
		logic done;
	} eng_sts_t;

endpackage

`default_nettype wire

>>> hdl/alm_engine.sv
// Element store and sequencer: one-read, one-write-port walk for shift and search.
// Depends on alm_pkg.
`default_nettype none

module alm_engine
	import alm_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire eng_ctl_t ctl,
	input  wire in_t      item,
	output eng_sts_t      sts,
	output out_t          result
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_WALK  = 3'd1;
	localparam logic [2:0] S_DRAIN = 3'd2;
	localparam logic [2:0] S_PUT   = 3'd3;
	localparam logic [2:0] S_RESP  = 3'd4;

	logic [2:0]    state_q;
	logic [2:0]    cmd_q;
	logic [31:0]   val_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] new_cnt_q;
	logic [1:0]    status_q;
	logic          found_q;
	logic [AW-1:0] ptr_q;
	logic [AW-1:0] last_q;
	logic [AW-1:0] mid_q;
	logic          down_q;

	logic          vld_s1;
	logic [AW-1:0] waddr_s1;
	logic [31:0]   rdata_s1;

	logic [31:0]   mem_q [CAPACITY];

	logic          we;
	logic [AW-1:0] waddr;
	logic [31:0]   wdata;
	logic [CW-1:0] half_c;
	logic          full_c;
	logic          empty_c;

	assign half_c  = cnt_q >> 1;
	assign full_c  = (cnt_q == CAP_C);
	assign empty_c = (cnt_q == '0);

	// one write port: append at start, shifted word from the walk, or the new middle word
	always_comb begin
		we    = 1'b0;
		waddr = waddr_s1;
		wdata = rdata_s1;
		if (state_q == S_IDLE && ctl.start && item.command == CMD_APPEND && !full_c) begin
			we    = 1'b1;
			waddr = AW'(cnt_q);
			wdata = item.value;
		end else if (vld_s1 && cmd_q != CMD_SEARCH) begin
			we = 1'b1;
		end else if (state_q == S_PUT) begin
			we    = 1'b1;
			waddr = mid_q;
			wdata = val_q;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_s1 <= mem_q[ptr_q];
		waddr_s1 <= down_q ? AW'(ptr_q + 1'b1) : AW'(ptr_q - 1'b1);
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && ctl.start) begin
			cmd_q    <= item.command;
			val_q    <= item.value;
			status_q <= ST_DONE;
			found_q  <= 1'b0;
			mid_q    <= AW'(half_c);
			last_q   <= AW'(half_c);
			case (item.command)
				CMD_APPEND: begin
					new_cnt_q <= full_c ? cnt_q : CW'(cnt_q + 1'b1);
					if (full_c) status_q <= ST_FULL;
				end
				CMD_DROP_LAST: begin
					new_cnt_q <= empty_c ? cnt_q : CW'(cnt_q - 1'b1);
					if (empty_c) status_q <= ST_EMPTY;
				end
				CMD_INSERT_MID: begin
					new_cnt_q <= full_c ? cnt_q : CW'(cnt_q + 1'b1);
					if (full_c) status_q <= ST_FULL;
					ptr_q  <= AW'(cnt_q - 1'b1);
					down_q <= 1'b1;
				end
				CMD_REMOVE_MID: begin
					new_cnt_q <= empty_c ? cnt_q : CW'(cnt_q - 1'b1);
					if (empty_c) status_q <= ST_EMPTY;
					ptr_q  <= AW'(half_c + 1'b1);
					last_q <= AW'(cnt_q - 1'b1);
					down_q <= 1'b0;
				end
				CMD_SEARCH: begin
					new_cnt_q <= cnt_q;
					ptr_q     <= '0;
					last_q    <= AW'(cnt_q - 1'b1);
					down_q    <= 1'b0;
				end
				CMD_CLEAR: begin
					new_cnt_q <= '0;
				end
				default: begin
					new_cnt_q <= cnt_q;
				end
			endcase
		end else if (state_q == S_WALK && ptr_q != last_q) begin
			ptr_q <= down_q ? AW'(ptr_q - 1'b1) : AW'(ptr_q + 1'b1);
		end
		if (vld_s1 && cmd_q == CMD_SEARCH && rdata_s1 == val_q) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			vld_s1  <= 1'b0;
		end else begin
			vld_s1 <= (state_q == S_WALK);
			case (state_q)
				S_IDLE: begin
					if (ctl.start) begin
						state_q <= S_RESP;
						case (item.command)
							CMD_INSERT_MID: begin
								if (!full_c) state_q <= empty_c ? S_PUT : S_WALK;
							end
							CMD_REMOVE_MID: begin
								if (!empty_c && CW'(half_c + 1'b1) < cnt_q) state_q <= S_WALK;
							end
							CMD_SEARCH: begin
								if (!empty_c) state_q <= S_WALK;
							end
							default: begin
								state_q <= S_RESP;
							end
						endcase
					end
				end
				S_WALK: begin
					if (ptr_q == last_q) state_q <= S_DRAIN;
				end
				S_DRAIN: begin
					state_q <= (cmd_q == CMD_INSERT_MID) ? S_PUT : S_RESP;
				end
				S_PUT: begin
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (ctl.take) begin
						cnt_q   <= new_cnt_q;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign sts.idle = (state_q == S_IDLE);
	assign sts.done = (state_q == S_RESP);

	assign result.status   = status_q;
	assign result.found    = found_q;
	assign result.count    = 7'(new_cnt_q);
	assign result.is_full  = (new_cnt_q == CAP_C);
	assign result.is_empty = (new_cnt_q == '0);

endmodule

`default_nettype wire

>>> hdl/array_list_middle_insert.sv
// Fixed-capacity ordered list of 32-bit words with middle insert/remove.
//
// Channels: req (command, value) in, res (status, found, count, is_full,
// is_empty) out, both valid/stall; an item moves when valid is high and
// stall is low. Every request item yields exactly one result item.
//
// Middle insert walks the upper half of the list and shifts it up, middle
// remove walks it and shifts it down when elements move, and search walks
// the whole list; other commands, refusals and empty lists do not walk.
// Work is serial through one element store with one read and one write
// port, one word read and one word written per cycle while walking, one
// item at a time.
// req_stall is high while an item is in the engine; the next item is taken
// the cycle after the result moves into the output register.
//
// A stalled result holds in the output register; the engine may finish
// the following item meanwhile and waits for the register to free up.
// Reset empties the list and drops any pending result. Stored words are
// not cleared; only entries below the count are ever read.
`default_nettype none

module array_list_middle_insert
	import alm_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_stall,
	input  wire in_t  req,
	output logic      res_valid,
	input  wire logic res_stall,
	output out_t      res
);

	eng_ctl_t ctl;
	eng_sts_t sts;
	out_t     eng_res;

	logic     res_valid_q;
	out_t     res_q;

	// take requests only when the engine sits idle
	assign req_stall = !sts.idle;
	assign ctl.start = req_valid && !req_stall;
	// output register free, or emptying this cycle
	assign ctl.take  = !res_valid_q || !res_stall;

	alm_engine #(
		.CAPACITY(CAPACITY)
	) u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.item   (req),
		.sts    (sts),
		.result (eng_res)
	);

	// load a finished result, drop it once taken, hold it while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (sts.done && ctl.take) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (sts.done && ctl.take) begin
			res_q <= eng_res;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	// an accepted item always makes the engine busy next cycle
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.start |=> !sts.idle)
		else $error("engine idle right after accepting an item");

	// a finished result handed over lands in the output register
	a_done_loads: assert property (@(posedge clk) disable iff (!arst_n)
		sts.done && ctl.take |=> res_valid_q)
		else $error("finished result not loaded");

	// refusals agree with the reported flags
	a_refuse_flags: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> ((res_q.status != ST_FULL || res_q.is_full) &&
			(res_q.status != ST_EMPTY || res_q.is_empty)))
		else $error("refusal status disagrees with full/empty flags");

endmodule

`default_nettype wire
